// File: hw/rtl/trot_foot_trajectory_per_leg_macros.svh
// assertion macros for the trot foot trajectory block
`ifndef TROT_FOOT_TRAJECTORY_PER_LEG_MACROS_SVH
`define TROT_FOOT_TRAJECTORY_PER_LEG_MACROS_SVH

`ifndef SYNTHESIS

`define TFT_ASSERT_COMB(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tft check failed");

`define TFT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tft implication check failed");

`else

`define TFT_ASSERT_COMB(label, cond)

`define TFT_ASSERT_IMPL(label, ante, cons)

`endif

`endif

// File: hw/rtl/tft_pkg.sv
// shared types, constants and functions of the trot foot trajectory block
package tft_pkg;

    localparam int unsigned TABLE_BITS_DEF = 12;

    localparam logic [15:0] PERIOD_RESET = 16'd100;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_RANGE  = 2'd1;
    localparam logic [1:0] STATUS_NO_LEG = 2'd2;

    localparam logic [27:0] INV_2PI_Q30 = 28'd170891319;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [1:0]         status;
        logic               swing;
        logic signed [15:0] stride;
        logic [14:0]        lift;
        logic signed [15:0] body;
    } side_t;

    // quarter-wave sine entry, q0.15, from a q30 taylor series
    function automatic logic [14:0] sine_entry(input longint unsigned k,
                                               input int unsigned tb);
        longint unsigned quarter;
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        quarter = 64'd1 << (tb - 2);
        x = (k * PI_HALF_Q30 + (quarter >> 1)) >> (tb - 2);
        term = x;
        sum = x;
        for (int n = 1; n <= 8; n++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                6: term = term / 64'd156;
                7: term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if ((n % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32767)
            return 15'h7fff;
        return v[14:0];
    endfunction

    function automatic logic signed [15:0] sat_q78(input logic signed [19:0] v);
        if (v > 20'sd32767)
            return 16'sh7fff;
        if (v < -20'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// File: hw/rtl/trot_foot_trajectory_per_leg.sv
// trot gait foot trajectory pipeline, top level
// One request is taken every clock (busy stays low). Each request passes
// through the restoring divider that turns time into table phase, one
// quotient bit per pipeline stage, followed by the sine table read and
// the multiply stages. The receiver cannot stall: each result is on
// foot_x, foot_z and status for exactly the one cycle in which
// result_valid is high. The user must write period_reg through
// cfg_we/cfg_wdata only while no request is in flight; the block itself
// does not enforce this.
`include "trot_foot_trajectory_per_leg_macros.svh"

module trot_foot_trajectory_per_leg
    import tft_pkg::*;
#(
    parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        time_ticks,
    input  logic [2:0]         leg_number,
    input  logic signed [15:0] stride_length,
    input  logic [14:0]        lift_height,
    input  logic signed [15:0] body_height,
    output logic               result_valid,
    output logic signed [15:0] foot_x,
    output logic signed [15:0] foot_z,
    output logic [1:0]         status
);

    localparam int unsigned QUARTER = 1 << (TABLE_BITS - 2);
    localparam int unsigned ADDR_W  = TABLE_BITS - 1;
    localparam int unsigned IDX_W   = TABLE_BITS + 1;
    localparam int unsigned DW      = TABLE_BITS + 17;
    localparam int unsigned NDIV    = TABLE_BITS + 1;

    logic [15:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_we)
            period_reg <= cfg_wdata;
    end

    assign busy = 1'b0;

    // stage a: range check, half-period select, leg role
    logic        a_vld_reg;
    logic [16:0] a_t2_reg;
    logic        a_first_reg;
    side_t       a_side_reg;
    logic [2:0]  leg_eff;
    logic        first_next;
    side_t       a_side_next;

    always_comb
    begin
        leg_eff = (leg_number > 3'd4) ? 3'd1 : leg_number;
        first_next = {time_ticks, 1'b0} <= {1'b0, period_reg};
        if ((period_reg == 16'd0) || (time_ticks > period_reg))
            a_side_next.status = STATUS_RANGE;
        else if (leg_eff == 3'd0)
            a_side_next.status = STATUS_NO_LEG;
        else
            a_side_next.status = STATUS_OK;
        a_side_next.swing = first_next ? ((leg_eff == 3'd1) || (leg_eff == 3'd4))
                                       : ((leg_eff == 3'd2) || (leg_eff == 3'd3));
        a_side_next.stride = stride_length;
        a_side_next.lift = lift_height;
        a_side_next.body = body_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        a_t2_reg <= {time_ticks, 1'b0};
        a_first_reg <= first_next;
        a_side_reg <= a_side_next;
    end

    // stage b: dividend for the rounded phase quotient
    logic          b_vld_reg;
    logic [DW-1:0] b_d_reg;
    side_t         b_side_reg;
    logic [15:0]   num;
    logic [DW-1:0] b_d_next;

    always_comb
    begin
        num = a_first_reg ? a_t2_reg[15:0] : 16'(a_t2_reg - {1'b0, period_reg});
        b_d_next = (DW'(num) << TABLE_BITS) + DW'(period_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        b_d_reg <= b_d_next;
        b_side_reg <= a_side_reg;
    end

    // restoring divider, one quotient bit per stage
    logic              dv_vld_reg  [NDIV];
    logic [15:0]       dv_rem_reg  [NDIV];
    logic [IDX_W-1:0]  dv_low_reg  [NDIV];
    logic [IDX_W-1:0]  dv_q_reg    [NDIV];
    side_t             dv_side_reg [NDIV];
    logic              dv_vld_in   [NDIV];
    logic [15:0]       dv_rem_in   [NDIV];
    logic [IDX_W-1:0]  dv_low_in   [NDIV];
    logic [IDX_W-1:0]  dv_q_in     [NDIV];
    side_t             dv_side_in  [NDIV];

    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        logic [16:0]      rs;
        logic             ge;
        logic [15:0]      rem_next;
        logic [IDX_W-1:0] q_next;

        if (j == 0)
        begin : g_first
            assign dv_vld_in[j]  = b_vld_reg;
            assign dv_rem_in[j]  = b_d_reg[DW-1:TABLE_BITS+1];
            assign dv_low_in[j]  = b_d_reg[TABLE_BITS:0];
            assign dv_q_in[j]    = '0;
            assign dv_side_in[j] = b_side_reg;
        end
        else
        begin : g_next
            assign dv_vld_in[j]  = dv_vld_reg[j-1];
            assign dv_rem_in[j]  = dv_rem_reg[j-1];
            assign dv_low_in[j]  = dv_low_reg[j-1];
            assign dv_q_in[j]    = dv_q_reg[j-1];
            assign dv_side_in[j] = dv_side_reg[j-1];
        end

        always_comb
        begin
            rs = {dv_rem_in[j], dv_low_in[j][TABLE_BITS-j]};
            ge = rs >= {1'b0, period_reg};
            rem_next = ge ? 16'(rs - {1'b0, period_reg}) : rs[15:0];
            q_next = {dv_q_in[j][TABLE_BITS-1:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j] <= 1'b0;
            else
                dv_vld_reg[j] <= dv_vld_in[j];
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j] <= rem_next;
            dv_low_reg[j] <= dv_low_in[j];
            dv_q_reg[j] <= q_next;
            dv_side_reg[j] <= dv_side_in[j];
        end
    end

    // quarter-wave sine rom, two registered reads
    logic [14:0] rom_const [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_rom
        assign rom_const[k] = sine_entry(64'(k), TABLE_BITS);
    end

    logic              rd_vld_reg;
    logic [14:0]       rd_a_reg;
    logic [14:0]       rd_b_reg;
    logic [1:0]        rd_quad_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    side_t             rd_side_reg;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    always_comb
    begin
        idx = dv_q_reg[NDIV-1];
        addr_a = {1'b0, idx[TABLE_BITS-3:0]};
        addr_b = ADDR_W'(QUARTER) - addr_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= dv_vld_reg[NDIV-1];
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= rom_const[addr_a];
        rd_b_reg <= rom_const[addr_b];
        rd_quad_reg <= idx[TABLE_BITS-1:TABLE_BITS-2];
        rd_idx_reg <= idx;
        rd_side_reg <= dv_side_reg[NDIV-1];
    end

    // quadrant folding of sine and cosine
    logic             sel_vld_reg;
    logic [14:0]      sel_smag_reg;
    logic             sel_sneg_reg;
    logic [16:0]      sel_zdiff_reg;
    logic [IDX_W-1:0] sel_idx_reg;
    side_t            sel_side_reg;
    logic [14:0]      c_mag;
    logic [16:0]      zdiff_next;

    always_comb
    begin
        c_mag = rd_quad_reg[0] ? rd_a_reg : rd_b_reg;
        if (rd_quad_reg[1] ^ rd_quad_reg[0])
            zdiff_next = 17'd32768 + {2'b0, c_mag};
        else
            zdiff_next = 17'd32768 - {2'b0, c_mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_vld_reg <= 1'b0;
        else
            sel_vld_reg <= rd_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        sel_smag_reg <= rd_quad_reg[0] ? rd_b_reg : rd_a_reg;
        sel_sneg_reg <= rd_quad_reg[1];
        sel_zdiff_reg <= zdiff_next;
        sel_idx_reg <= rd_idx_reg;
        sel_side_reg <= rd_side_reg;
    end

    // sine over two pi and lift products
    logic             mul_vld_reg;
    logic [42:0]      mul_sprod_reg;
    logic [31:0]      mul_zprod_reg;
    logic             mul_sneg_reg;
    logic [IDX_W-1:0] mul_idx_reg;
    side_t            mul_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else
            mul_vld_reg <= sel_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        mul_sprod_reg <= 43'(sel_smag_reg) * 43'(INV_2PI_Q30);
        mul_zprod_reg <= 32'(sel_side_reg.lift) * 32'(sel_zdiff_reg);
        mul_sneg_reg <= sel_sneg_reg;
        mul_idx_reg <= sel_idx_reg;
        mul_side_reg <= sel_side_reg;
    end

    // x shape term in q30, z target
    logic               gt_vld_reg;
    logic signed [31:0] gt_g_reg;
    logic signed [15:0] gt_z_reg;
    side_t              gt_side_reg;
    logic [27:0]        sterm;
    logic [31:0]        idx_term;
    logic signed [31:0] sterm_s;
    logic signed [31:0] g_next;
    logic [15:0]        zsw;
    logic signed [17:0] body_ext;
    logic signed [19:0] z_wide;

    always_comb
    begin
        sterm = 28'((mul_sprod_reg + 43'd16384) >> 15);
        idx_term = 32'(mul_idx_reg) << (30 - TABLE_BITS);
        sterm_s = mul_sneg_reg ? -$signed({4'b0, sterm}) : $signed({4'b0, sterm});
        g_next = 32'sd536870912 - $signed(idx_term) + sterm_s;
        zsw = 16'((mul_zprod_reg + 32'd32768) >> 16);
        body_ext = {{2{mul_side_reg.body[15]}}, mul_side_reg.body};
        if (mul_side_reg.swing)
            z_wide = 20'($signed({2'b0, zsw}) - body_ext);
        else
            z_wide = 20'(-body_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gt_vld_reg <= 1'b0;
        else
            gt_vld_reg <= mul_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        gt_g_reg <= g_next;
        gt_z_reg <= sat_q78(z_wide);
        gt_side_reg <= mul_side_reg;
    end

    // stride times shape term
    logic               px_vld_reg;
    logic signed [47:0] px_prod_reg;
    logic signed [15:0] px_z_reg;
    side_t              px_side_reg;
    logic signed [15:0] stride_s;
    logic signed [47:0] px_prod_next;

    always_comb
    begin
        stride_s = gt_side_reg.stride;
        px_prod_next = stride_s * gt_g_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            px_vld_reg <= 1'b0;
        else
            px_vld_reg <= gt_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        px_prod_reg <= px_prod_next;
        px_z_reg <= gt_z_reg;
        px_side_reg <= gt_side_reg;
    end

    // rounding, stance negation, saturation, error zeroing
    logic               result_valid_reg;
    logic signed [15:0] foot_x_reg;
    logic signed [15:0] foot_z_reg;
    logic [1:0]         status_reg;
    logic signed [47:0] rnd;
    logic signed [17:0] xr;
    logic signed [19:0] x_wide;
    logic signed [15:0] foot_x_next;
    logic signed [15:0] foot_z_next;

    always_comb
    begin
        rnd = px_prod_reg + 48'sd536870912 - $signed({47'b0, px_prod_reg[47]});
        xr = 18'(rnd >>> 30);
        if (px_side_reg.swing)
            x_wide = {{2{xr[17]}}, xr};
        else
            x_wide = -$signed({{2{xr[17]}}, xr});
        if (px_side_reg.status == STATUS_OK)
        begin
            foot_x_next = sat_q78(x_wide);
            foot_z_next = px_z_reg;
        end
        else
        begin
            foot_x_next = 16'sd0;
            foot_z_next = 16'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= px_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        foot_x_reg <= foot_x_next;
        foot_z_reg <= foot_z_next;
        status_reg <= px_side_reg.status;
    end

    assign result_valid = result_valid_reg;
    assign foot_x = foot_x_reg;
    assign foot_z = foot_z_reg;
    assign status = status_reg;

    `TFT_ASSERT_IMPL(a_zero_on_error, result_valid_reg && (status_reg != STATUS_OK), (foot_x_reg == 16'sd0) && (foot_z_reg == 16'sd0))
    `TFT_ASSERT_IMPL(a_phase_in_range, dv_vld_reg[NDIV-1] && (dv_side_reg[NDIV-1].status == STATUS_OK), dv_q_reg[NDIV-1] <= IDX_W'(1 << TABLE_BITS))
    `TFT_ASSERT_IMPL(a_rem_below_period, dv_vld_reg[NDIV-1] && (dv_side_reg[NDIV-1].status == STATUS_OK), dv_rem_reg[NDIV-1] < period_reg)

endmodule
